/* rtl/uera_pkg.sv */
// shared types, register codes and constants for the ultrasonic echo ranger
// used by every rtl module of the ranger; depends on nothing
package uera_pkg;

   // register widths and reset values
   localparam int TRIG_W   = 8;
   localparam int TOUT_W   = 16;
   localparam int BURST_W  = 4;
   localparam int THR_W    = 11;
   localparam int AVG_W    = 16;
   localparam int DIST_W   = 11;
   localparam int SUM_W    = 20;
   localparam int DEN_W    = 6;
   localparam int DIV_BITS = SUM_W;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   localparam logic [TRIG_W-1:0]  TRIGGER_WIDTH_RESET = 8'd10;
   localparam logic [TOUT_W-1:0]  RISE_TIMEOUT_RESET  = 16'd5000;
   localparam logic [TOUT_W-1:0]  ECHO_TIMEOUT_RESET  = 16'd65000;
   localparam logic [BURST_W-1:0] BURST_COUNT_RESET   = 4'd10;
   localparam logic [THR_W-1:0]   THRESHOLD_RESET     = 11'd10;

   localparam logic [DEN_W-1:0] US_PER_CM = 6'd58;

   // division by 58 as a reciprocal multiply, exact for every 16-bit average
   localparam int               RECIP_W     = 17;
   localparam int               RECIP_SHIFT = 22;
   localparam logic [RECIP_W-1:0] CM_RECIP  = 17'd72316;  // ceil(2^22 / 58)

   localparam int TICK_COUNTER_BITS_DEFAULT = 16;

   // register indexes (byte address bits [4:2])
   localparam logic [2:0] REG_TRIGGER_WIDTH = 3'd0;
   localparam logic [2:0] REG_RISE_TIMEOUT  = 3'd1;
   localparam logic [2:0] REG_ECHO_TIMEOUT  = 3'd2;
   localparam logic [2:0] REG_BURST_COUNT   = 3'd3;
   localparam logic [2:0] REG_THRESHOLD     = 3'd4;

   // ranging phase codes
   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_TRIGGER   = 2'd1;
   localparam logic [1:0] PH_WAIT_RISE = 2'd2;
   localparam logic [1:0] PH_MEASURE   = 2'd3;

   typedef struct packed {
      logic [TRIG_W-1:0]  trigger_width_us;
      logic [TOUT_W-1:0]  rise_timeout_us;
      logic [TOUT_W-1:0]  echo_timeout_us;
      logic [BURST_W-1:0] burst_count;
      logic [THR_W-1:0]   obstacle_threshold_cm;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic step;       // process the accepted tick word
      logic div_iter;   // one divider step
      logic avg_done;   // keep average
      logic dist_done;  // keep distance and obstacle flag
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic store;      // this tick closes a burst with a valid reading
   } status_type;

endpackage

/* rtl/ultrasonic_echo_ranger_averaging.sv */
// top level of the ultrasonic echo ranger with burst averaging
// depends on uera_pkg, uera_csr, uera_ctrl and uera_dp
//
// Each input word is one microsecond tick carrying the enable bit and the sampled
// echo level; each accepted word gives exactly one result word with the trigger
// level for that tick, a store flag and the held average width, distance (average
// divided by 58) and obstacle flag. A tick that does not close a burst has its result
// registered on the accept edge, and the next word can be taken in the cycle the
// result is taken. A tick that closes a burst with at least one valid reading runs
// the one-bit-per-clock divider for 20 steps for the average, then keeps the average,
// then forms the distance by a reciprocal multiply and the obstacle flag; no word is
// taken meanwhile. Registers are written through the apb-style port (byte address
// 4*index) and take effect at once; no clearing pass follows reset.
module ultrasonic_echo_ranger_averaging #(
   parameter int TICK_COUNTER_BITS = uera_pkg::TICK_COUNTER_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // tick words in
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_enable,
   input  logic                          req_echo_level,
   // result words out
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_trigger_level,
   output logic                          rsp_result_valid,
   output logic [uera_pkg::AVG_W-1:0]    rsp_average_us,
   output logic [uera_pkg::DIST_W-1:0]   rsp_distance_cm,
   output logic                          rsp_obstacle,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [uera_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [uera_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [uera_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import uera_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   uera_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake and divide sequencing
   uera_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // ranging datapath
   uera_dp #(
      .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_enable        (req_enable),
      .req_echo_level    (req_echo_level),
      .rsp_trigger_level (rsp_trigger_level),
      .rsp_result_valid  (rsp_result_valid),
      .rsp_average_us    (rsp_average_us),
      .rsp_distance_cm   (rsp_distance_cm),
      .rsp_obstacle      (rsp_obstacle)
   );

endmodule

/* rtl/uera_csr.sv */
// configuration registers behind the apb-style port
// depends on uera_pkg for register codes, widths and reset values
module uera_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [uera_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [uera_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [uera_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output uera_pkg::cfg_type             cfg
);
   import uera_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index  = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_TRIGGER_WIDTH: cfg_in.trigger_width_us      = csr_pwdata[TRIG_W-1:0];
            REG_RISE_TIMEOUT:  cfg_in.rise_timeout_us       = csr_pwdata[TOUT_W-1:0];
            REG_ECHO_TIMEOUT:  cfg_in.echo_timeout_us       = csr_pwdata[TOUT_W-1:0];
            REG_BURST_COUNT:   cfg_in.burst_count           = csr_pwdata[BURST_W-1:0];
            REG_THRESHOLD:     cfg_in.obstacle_threshold_cm = csr_pwdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_width_us      <= TRIGGER_WIDTH_RESET;
         cfg_ff.rise_timeout_us       <= RISE_TIMEOUT_RESET;
         cfg_ff.echo_timeout_us       <= ECHO_TIMEOUT_RESET;
         cfg_ff.burst_count           <= BURST_COUNT_RESET;
         cfg_ff.obstacle_threshold_cm <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         REG_TRIGGER_WIDTH: csr_prdata = DATA_W'(cfg_ff.trigger_width_us);
         REG_RISE_TIMEOUT:  csr_prdata = DATA_W'(cfg_ff.rise_timeout_us);
         REG_ECHO_TIMEOUT:  csr_prdata = DATA_W'(cfg_ff.echo_timeout_us);
         REG_BURST_COUNT:   csr_prdata = DATA_W'(cfg_ff.burst_count);
         REG_THRESHOLD:     csr_prdata = DATA_W'(cfg_ff.obstacle_threshold_cm);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

/* rtl/uera_ctrl.sv */
// controller: word handshakes and the divide sequence at burst end
// depends on uera_pkg for the command and status structs
module uera_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  uera_pkg::status_type status,
   output uera_pkg::cmd_type    cmd
);
   import uera_pkg::*;

   localparam logic [2:0] C_IDLE      = 3'd0;
   localparam logic [2:0] C_DIV_AVG   = 3'd1;
   localparam logic [2:0] C_LOAD_DIST = 3'd2;
   localparam logic [2:0] C_FINISH    = 3'd4;

   localparam int CNT_W = $clog2(DIV_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_BITS - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_ready = (state_ff == C_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         C_IDLE: begin
            if (accept) begin
               cmd.step = 1'b1;
               cnt_in   = '0;
               if (status.store) begin
                  state_in     = C_DIV_AVG;
                  rsp_valid_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         C_DIV_AVG: begin
            cmd.div_iter = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = C_LOAD_DIST;
            end
         end
         C_LOAD_DIST: begin
            cmd.avg_done = 1'b1;
            cnt_in       = '0;
            state_in     = C_FINISH;
         end
         C_FINISH: begin
            cmd.dist_done = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // no word is offered while a burst average is being divided
   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != C_IDLE) |-> !rsp_valid_ff)
      else $error("result word offered during divide");

   // a tick that closes a burst starts the average divide
   a_store_starts_div: assert property (@(posedge clock) disable iff (reset)
      (accept && status.store) |=> (state_ff == C_DIV_AVG))
      else $error("burst end did not start divide");

   // the divide sequence ends by offering its word
   a_finish_offers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_FINISH) |=> (rsp_valid_ff && state_ff == C_IDLE))
      else $error("finished divide did not offer a word");

endmodule

/* rtl/uera_dp.sv */
// datapath: ranging phase, burst accumulators, serial divider, held results
// depends on uera_pkg for phase codes, widths and command/status structs
module uera_dp #(
   parameter int TICK_COUNTER_BITS = uera_pkg::TICK_COUNTER_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  uera_pkg::cfg_type             cfg,
   input  uera_pkg::cmd_type             cmd,
   output uera_pkg::status_type          status,
   input  logic                          req_enable,
   input  logic                          req_echo_level,
   output logic                          rsp_trigger_level,
   output logic                          rsp_result_valid,
   output logic [uera_pkg::AVG_W-1:0]    rsp_average_us,
   output logic [uera_pkg::DIST_W-1:0]   rsp_distance_cm,
   output logic                          rsp_obstacle
);
   import uera_pkg::*;

   localparam int TB    = TICK_COUNTER_BITS;
   localparam int LIM_W = (TB > TOUT_W) ? TB : TOUT_W;
   localparam int PROD_W = AVG_W + RECIP_W;
   localparam logic [TB-1:0]    TICK_ALL = {TB{1'b1}};
   localparam logic [LIM_W-1:0] TICK_MAX = LIM_W'(TICK_ALL);

   // ranging state
   logic [1:0]         phase_ff, phase_in;
   logic [TB-1:0]      ticks_ff, ticks_in;
   logic [BURST_W-1:0] index_ff, index_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [BURST_W-1:0] count_ff, count_in;

   // held results and output word
   logic [AVG_W-1:0]   average_ff;
   logic [DIST_W-1:0]  distance_ff;
   logic               obstacle_ff;
   logic               trig_ff;
   logic               stored_ff;

   // serial divider
   logic [DIV_BITS-1:0] div_quo_ff;
   logic [DEN_W-1:0]    div_rem_ff;
   logic [DEN_W-1:0]    div_den_ff;
   logic [DEN_W:0]      div_trial;
   logic [DEN_W:0]      div_diff;
   logic                div_ge;

   // distance by reciprocal multiply
   logic [PROD_W-1:0]  dist_prod;
   logic [DIST_W-1:0]  dist_q;

   // tick step signals
   logic               trig;
   logic               fin;
   logic               fin_valid;
   logic [AVG_W-1:0]   fin_width;
   logic               store;
   logic [SUM_W-1:0]   burst_sum;
   logic [BURST_W-1:0] burst_cnt;
   logic [BURST_W-1:0] need;
   logic [TB-1:0]      ticks_sat;
   logic [LIM_W-1:0]   ticks_ext;
   logic [LIM_W-1:0]   lim_trig, lim_rise, lim_echo;

   function automatic logic [LIM_W-1:0] limit_of(input logic [LIM_W-1:0] t);
      return (t < TICK_MAX) ? t : TICK_MAX;
   endfunction

   assign lim_trig = limit_of(LIM_W'(cfg.trigger_width_us));
   assign lim_rise = limit_of(LIM_W'(cfg.rise_timeout_us));
   assign lim_echo = limit_of(LIM_W'(cfg.echo_timeout_us));
   assign need     = (cfg.burst_count == '0) ? BURST_W'(1) : cfg.burst_count;

   // one tick of the ranging sequence
   always_comb begin
      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      index_in  = index_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      trig      = 1'b0;
      fin       = 1'b0;
      fin_valid = 1'b0;
      fin_width = '0;
      store     = 1'b0;
      burst_sum = '0;
      burst_cnt = '0;
      // burst start
      if (phase_in == PH_IDLE && req_enable) begin
         index_in = '0;
         sum_in   = '0;
         count_in = '0;
         phase_in = PH_TRIGGER;
         ticks_in = '0;
      end
      ticks_sat = (ticks_in == TICK_ALL) ? ticks_in : ticks_in + 1'b1;
      ticks_ext = LIM_W'(ticks_in);
      unique case (phase_in)
         PH_IDLE: begin
         end
         PH_TRIGGER: begin
            trig     = 1'b1;
            ticks_in = ticks_sat;
            if (LIM_W'(ticks_sat) >= lim_trig) begin
               phase_in = PH_WAIT_RISE;
               ticks_in = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (req_echo_level) begin
               phase_in = PH_MEASURE;
               ticks_in = TB'(1);
               if (lim_echo <= LIM_W'(1)) begin
                  fin       = 1'b1;
                  fin_valid = 1'b1;
                  fin_width = cfg.echo_timeout_us;
               end
            end else begin
               ticks_in = ticks_sat;
               if (LIM_W'(ticks_sat) >= lim_rise) begin
                  fin = 1'b1;
               end
            end
         end
         PH_MEASURE: begin
            if (!req_echo_level) begin
               fin       = 1'b1;
               fin_valid = 1'b1;
               fin_width = ticks_ext[AVG_W-1:0];
            end else begin
               ticks_in = ticks_sat;
               if (LIM_W'(ticks_sat) >= lim_echo) begin
                  fin       = 1'b1;
                  fin_valid = 1'b1;
                  fin_width = cfg.echo_timeout_us;
               end
            end
         end
         default: begin
         end
      endcase
      // end of one reading
      if (fin) begin
         if (fin_valid) begin
            sum_in   = sum_in + SUM_W'(fin_width);
            count_in = count_in + 1'b1;
         end
         index_in = index_in + 1'b1;
         ticks_in = '0;
         if (index_in >= need) begin
            store     = (count_in != '0);
            burst_sum = sum_in;
            burst_cnt = count_in;
            index_in  = '0;
            sum_in    = '0;
            count_in  = '0;
            phase_in  = req_enable ? PH_TRIGGER : PH_IDLE;
         end else begin
            phase_in = PH_TRIGGER;
         end
      end
   end

   assign status.store = store;

   // ranging state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
         index_ff <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.step) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         index_ff <= index_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   // per-word trigger level and store flag
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         trig_ff   <= trig;
         stored_ff <= store;
      end
   end

   // restoring divider step, one quotient bit per cycle
   assign div_trial = {div_rem_ff, div_quo_ff[DIV_BITS-1]};
   assign div_ge    = div_trial >= {1'b0, div_den_ff};
   assign div_diff  = div_trial - {1'b0, div_den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_rem_ff <= '0;
         div_den_ff <= DEN_W'(1);
      end else if (cmd.step && store) begin
         div_quo_ff <= burst_sum;
         div_den_ff <= DEN_W'(burst_cnt);
         div_rem_ff <= '0;
      end else if (cmd.div_iter) begin
         div_quo_ff <= {div_quo_ff[DIV_BITS-2:0], div_ge};
         div_rem_ff <= div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
      end
   end

   // distance in cm from the held average
   assign dist_prod = PROD_W'(average_ff) * PROD_W'(CM_RECIP);
   assign dist_q    = dist_prod[RECIP_SHIFT +: DIST_W];

   // held average, distance and obstacle flag
   always_ff @(posedge clock) begin
      if (reset) begin
         average_ff  <= '0;
         distance_ff <= '0;
         obstacle_ff <= 1'b0;
      end else begin
         if (cmd.avg_done) begin
            average_ff <= div_quo_ff[AVG_W-1:0];
         end
         if (cmd.dist_done) begin
            distance_ff <= dist_q;
            obstacle_ff <= dist_q < cfg.obstacle_threshold_cm;
         end
      end
   end

   assign rsp_trigger_level = trig_ff;
   assign rsp_result_valid  = stored_ff;
   assign rsp_average_us    = average_ff;
   assign rsp_distance_cm   = distance_ff;
   assign rsp_obstacle      = obstacle_ff;

   // divider remainder always stays below its divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      div_rem_ff < div_den_ff)
      else $error("divider remainder not below divisor");

   // a tick handled in the trigger phase drives the trigger high
   a_trigger_high: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && phase_ff == PH_TRIGGER) |=> trig_ff)
      else $error("trigger low during trigger phase");

endmodule

/* tb/sv/ultrasonic_echo_ranger_averaging_tb.sv */
// self-checking testbench for the ultrasonic echo ranger with burst averaging
// drives tick words through the req/rsp handshakes and checks every result word
// against a local prediction; depends on uera_pkg and the ranger rtl
module ultrasonic_echo_ranger_averaging_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uera_pkg::*;

   localparam int TICK_BITS   = TICK_COUNTER_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 400;
   localparam int HOLD_AT     = 300;

   typedef struct packed {
      logic enable;
      logic echo;
   } tick_word_type;

   typedef struct packed {
      logic [1:0]           phase;
      logic [TICK_BITS-1:0] ticks;
      logic [BURST_W-1:0]   reading;
      logic [SUM_W-1:0]     width_sum;
      logic [BURST_W-1:0]   valid_count;
      logic [AVG_W-1:0]     average;
      logic                 obstacle;
   } ranger_state_type;

   typedef struct packed {
      logic              trigger;
      logic              stored;
      logic [AVG_W-1:0]  average;
      logic [DIST_W-1:0] distance;
      logic              obstacle;
   } tick_result_type;

   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

   logic clock;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic req_enable = 1'b0;
   logic req_echo_level = 1'b0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_trigger_level;
   logic              rsp_result_valid;
   logic [AVG_W-1:0]  rsp_average_us;
   logic [DIST_W-1:0] rsp_distance_cm;
   logic              rsp_obstacle;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   // predictor copy of the registers and of the ranging state
   cfg_type          ranger_regs = '{TRIGGER_WIDTH_RESET, RISE_TIMEOUT_RESET,
                                     ECHO_TIMEOUT_RESET, BURST_COUNT_RESET,
                                     THRESHOLD_RESET};
   ranger_state_type ranger_now = '0;

   tick_word_type   tick_plan[$];
   tick_result_type predicted_outputs[$];

   int queued_total = 0;
   int accepted_total = 0;
   int results_seen = 0;
   int fail_count = 0;
   int cycles = 0;

   tick_word_type   cur_word;
   tick_result_type want_word;
   int              send_gap = 0;
   int              send_fast = 0;
   int              recv_hold = 0;
   int              recv_fast = 0;
   logic            long_hold_done = 1'b0;
   logic            sender_busy;

   ultrasonic_echo_ranger_averaging u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_enable        (req_enable),
      .req_echo_level    (req_echo_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_trigger_level (rsp_trigger_level),
      .rsp_result_valid  (rsp_result_valid),
      .rsp_average_us    (rsp_average_us),
      .rsp_distance_cm   (rsp_distance_cm),
      .rsp_obstacle      (rsp_obstacle),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // timeouts clip to what the tick counter can reach
   function automatic logic [TICK_BITS-1:0] tick_limit(input logic [TOUT_W-1:0] t);
      return (t < TICK_MAX) ? TICK_BITS'(t) : TICK_MAX;
   endfunction

   // closes one reading, averages at burst end; returns 1 when a new average is kept
   function automatic logic close_reading(inout ranger_state_type st, input cfg_type c,
                                          input logic ok, input logic [AVG_W-1:0] w,
                                          input logic en);
      logic [BURST_W-1:0] need;
      logic               kept;
      need = (c.burst_count == 0) ? BURST_W'(1) : c.burst_count;
      kept = 1'b0;
      if (ok) begin
         st.width_sum   = st.width_sum + SUM_W'(w);
         st.valid_count = st.valid_count + 1'b1;
      end
      st.reading = st.reading + 1'b1;
      st.ticks = '0;
      if (st.reading >= need) begin
         if (st.valid_count != 0) begin
            st.average  = AVG_W'(st.width_sum / SUM_W'(st.valid_count));
            st.obstacle = (st.average / AVG_W'(US_PER_CM)) < AVG_W'(c.obstacle_threshold_cm);
            kept = 1'b1;
         end
         st.reading     = '0;
         st.width_sum   = '0;
         st.valid_count = '0;
         st.phase = en ? PH_TRIGGER : PH_IDLE;
      end else begin
         st.phase = PH_TRIGGER;
      end
      return kept;
   endfunction

   // one microsecond tick of the ranger
   function automatic tick_result_type predict_tick(inout ranger_state_type st,
                                                    input cfg_type c,
                                                    input logic en, input logic echo);
      tick_result_type r;
      logic            kept;
      r.trigger = 1'b0;
      kept = 1'b0;
      if (st.phase == PH_IDLE && en) begin
         st.reading     = '0;
         st.width_sum   = '0;
         st.valid_count = '0;
         st.phase       = PH_TRIGGER;
         st.ticks       = '0;
      end
      case (st.phase)
         PH_TRIGGER: begin
            r.trigger = 1'b1;
            if (st.ticks != TICK_MAX) st.ticks = st.ticks + 1'b1;
            if (st.ticks >= TICK_BITS'(c.trigger_width_us)) begin
               st.phase = PH_WAIT_RISE;
               st.ticks = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (echo) begin
               st.phase = PH_MEASURE;
               st.ticks = TICK_BITS'(1);
               if (st.ticks >= tick_limit(c.echo_timeout_us))
                  kept = close_reading(st, c, 1'b1, c.echo_timeout_us, en);
            end else begin
               if (st.ticks != TICK_MAX) st.ticks = st.ticks + 1'b1;
               if (st.ticks >= tick_limit(c.rise_timeout_us))
                  kept = close_reading(st, c, 1'b0, '0, en);
            end
         end
         PH_MEASURE: begin
            if (!echo) begin
               kept = close_reading(st, c, 1'b1, AVG_W'(st.ticks), en);
            end else begin
               if (st.ticks != TICK_MAX) st.ticks = st.ticks + 1'b1;
               if (st.ticks >= tick_limit(c.echo_timeout_us))
                  kept = close_reading(st, c, 1'b1, c.echo_timeout_us, en);
            end
         end
         default: ;
      endcase
      r.stored   = kept;
      r.average  = st.average;
      r.distance = DIST_W'(st.average / AVG_W'(US_PER_CM));
      r.obstacle = st.obstacle;
      return r;
   endfunction

   // idle cycles before the next word, with runs of back-to-back words
   function automatic int draw_gap(inout int fast_left);
      if (fast_left > 0) begin
         fast_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         fast_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   task automatic queue_tick(input logic en, input logic echo);
      tick_word_type w;
      w.enable = en;
      w.echo   = echo;
      tick_plan.push_back(w);
      queued_total++;
   endtask

   // echo waveforms that follow the ranger's own phases, with some glitches mixed in
   task automatic plan_ticks(input int count);
      ranger_state_type sim;
      logic             en;
      logic             echo;
      int               rise_at;
      int               echo_len;
      int               i;
      sim = ranger_now;
      rise_at = 0;
      echo_len = 1;
      for (i = 0; i < count; i++) begin
         if (sim.phase == PH_TRIGGER) begin
            if (ranger_regs.rise_timeout_us <= 40 && $urandom_range(0, 4) == 0)
               rise_at = 70000;
            else
               rise_at = $urandom_range(0, (ranger_regs.rise_timeout_us < 12) ?
                                        int'(ranger_regs.rise_timeout_us) : 12);
            if (ranger_regs.echo_timeout_us <= 60)
               echo_len = $urandom_range(1, int'(ranger_regs.echo_timeout_us) + 2);
            else
               echo_len = $urandom_range(1, 300);
         end
         if (sim.phase == PH_IDLE)
            en = ($urandom_range(0, 2) != 0);
         else
            en = ($urandom_range(0, 99) >= 4);
         case (sim.phase)
            PH_WAIT_RISE: echo = (int'(sim.ticks) >= rise_at);
            PH_MEASURE:   echo = (int'(sim.ticks) < echo_len);
            default:      echo = $urandom_range(0, 1);
         endcase
         if ($urandom_range(0, 99) < 6) echo = ~echo;
         void'(predict_tick(sim, ranger_regs, en, echo));
         queue_tick(en, echo);
      end
   endtask

   task automatic wait_drained();
      while (!(accepted_total == queued_total && predicted_outputs.size() == 0))
         @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle
   task automatic csr_write(input logic [2:0] index, input int value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(input int tw, input int rt, input int et, input int bc,
                                 input int thr);
      csr_write(REG_TRIGGER_WIDTH, tw);
      csr_write(REG_RISE_TIMEOUT, rt);
      csr_write(REG_ECHO_TIMEOUT, et);
      csr_write(REG_BURST_COUNT, bc);
      csr_write(REG_THRESHOLD, thr);
      ranger_regs.trigger_width_us      = TRIG_W'(tw);
      ranger_regs.rise_timeout_us       = TOUT_W'(rt);
      ranger_regs.echo_timeout_us       = TOUT_W'(et);
      ranger_regs.burst_count           = BURST_W'(bc);
      ranger_regs.obstacle_threshold_cm = THR_W'(thr);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // tick word driver, predicts each word as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         sender_busy = req_valid;
         if (req_valid && req_ready) begin
            predicted_outputs.push_back(predict_tick(ranger_now, ranger_regs,
                                                     cur_word.enable, cur_word.echo));
            accepted_total++;
            sender_busy = 1'b0;
            send_gap = draw_gap(send_fast);
         end
         if (!sender_busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (tick_plan.size() > 0) begin
               cur_word = tick_plan.pop_front();
               req_valid      <= 1'b1;
               req_enable     <= cur_word.enable;
               req_echo_level <= cur_word.echo;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result word monitor with random back-pressure and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               $display("%0t: result word with nothing expected", $time);
               fail_count++;
            end else begin
               want_word = predicted_outputs.pop_front();
               check_field("trigger_level", want_word.trigger, rsp_trigger_level);
               check_field("result_valid", want_word.stored, rsp_result_valid);
               check_field("average_us", want_word.average, rsp_average_us);
               check_field("distance_cm", want_word.distance, rsp_distance_cm);
               check_field("obstacle", want_word.obstacle, rsp_obstacle);
            end
            results_seen++;
            recv_hold = draw_gap(recv_fast);
            if (!long_hold_done && results_seen == HOLD_AT) begin
               recv_hold = LONG_HOLD;
               long_hold_done = 1'b1;
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // stimulus sequence
   initial begin
      int i;
      int p;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle with both echo levels, then a burst start and its trigger
      queue_tick(1'b0, 1'b0);
      queue_tick(1'b0, 1'b1);
      for (i = 0; i < 10; i++) queue_tick(1'b1, i[0]);
      wait_drained();

      // zero trigger width and burst count, short timeouts, from the rise wait
      apply_settings(0, 2, 3, 0, 1);
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b1, 1'b0);     // no rise: dropped, empty burst
      queue_tick(1'b1, 1'b1);     // one trigger tick
      queue_tick(1'b1, 1'b1);     // rise counts as first width tick
      queue_tick(1'b1, 1'b1);
      queue_tick(1'b1, 1'b0);     // width 2 stored
      queue_tick(1'b1, 1'b1);
      queue_tick(1'b1, 1'b1);
      queue_tick(1'b1, 1'b1);
      queue_tick(1'b1, 1'b1);     // echo timeout stored
      queue_tick(1'b0, 1'b1);     // running burst ignores enable low
      queue_tick(1'b0, 1'b1);
      queue_tick(1'b0, 1'b0);     // burst ends into idle
      queue_tick(1'b0, 1'b0);
      wait_drained();

      // zero and one register values
      apply_settings(0, 0, 0, 0, 0);
      plan_ticks(30);
      wait_drained();
      apply_settings(1, 1, 1, 1, 1);
      plan_ticks(30);
      wait_drained();

      // largest trigger width and timeouts, then the longest burst and largest threshold
      apply_settings(255, 65535, 65535, 1, 1130);
      plan_ticks(300);
      wait_drained();
      apply_settings(1, 3, 8, 15, 2047);
      plan_ticks(160);
      wait_drained();

      // random small settings
      for (p = 0; p < 8; p++) begin
         apply_settings($urandom_range(0, 4), $urandom_range(0, 12),
                        ($urandom_range(0, 2) == 0) ? $urandom_range(60, 150) :
                                                      $urandom_range(0, 20),
                        $urandom_range(0, 4),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) :
                                                      $urandom_range(0, 3));
         plan_ticks(12);
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
